// ===== hw/rtl/sgr_pkg.sv =====
package sgr_pkg;

   // Pointer operation codes
   localparam logic [1:0] OP_PRESS   = 2'd0;
   localparam logic [1:0] OP_MOVE    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_CANCEL  = 2'd3;

   // Result event codes
   localparam logic [1:0] EV_NONE      = 2'd0;
   localparam logic [1:0] EV_STARTED   = 2'd1;
   localparam logic [1:0] EV_TRIGGERED = 2'd2;
   localparam logic [1:0] EV_CANCELLED = 2'd3;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] REG_REGION_MIN_X = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_REGION_MAX_X = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_REGION_MIN_Y = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_REGION_MAX_Y = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_BOUND_ENABLE = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SWIPE_AXIS   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_DISTANCE = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_INTERVAL = 3'd7;

   // Register reset values
   localparam logic signed [15:0] RST_REGION_MIN = 16'sd0;
   localparam logic signed [15:0] RST_REGION_MAX = 16'sd32767;
   localparam logic [3:0]         RST_BOUND_EN   = 4'hF;
   localparam logic [15:0]        RST_MIN_INTERVAL = 16'd500;

   // Speed format: signed Q16.16
   localparam int SPEED_W = 32;
   localparam int FRAC_W  = 16;

   typedef struct packed {
      logic signed [15:0] region_min_x;
      logic signed [15:0] region_max_x;
      logic signed [15:0] region_min_y;
      logic signed [15:0] region_max_y;
      logic [3:0]         bound_enable;
      logic               swipe_axis;
      logic [15:0]        min_distance;
      logic [15:0]        min_interval;
   } sgr_cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic start_div;
      logic step_div;
      logic commit;
   } sgr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_speed;
      logic div_last;
   } sgr_sts_type;

endpackage

// ===== hw/rtl/swipe_gesture_recognizer.sv =====
// Channel   Direction  Accept when           Payload
// req_*     in         tvalid && tready      tuser: op; tdata: pos_x, pos_y, time_ms
// rsp_*     out        tvalid && tready      tuser: event_res; tdata: duration_ms, speed
// csr_*     in         csr_we                csr_addr selects register, csr_wdata value
//
// An item passes through accept, evaluate and commit when no speed is computed, and
// through a divide step between evaluate and commit when a move or release samples a
// speed: the restoring divider retires one quotient bit per cycle.
// Reset is synchronous and active high; it restores register defaults and disarms.
// A new item is accepted while the previous result waits on rsp; commit stalls only
// when a result is still pending and rsp_tready is low.
module swipe_gesture_recognizer #(
   parameter int COORD_WIDTH = 16,
   parameter int TIME_WIDTH  = 32
) (
   input  logic clock,
   input  logic reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,   // [1:0] op
   input  logic [((2*COORD_WIDTH+TIME_WIDTH+7)/8)*8-1:0] req_tdata,
                                 // pos_x, pos_y, time_ms from bit 0 up, zero pad
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_tuser,   // [1:0] event_res
   output logic [((TIME_WIDTH+sgr_pkg::SPEED_W+7)/8)*8-1:0] rsp_tdata,
                                 // duration_ms, speed from bit 0 up, zero pad
   // configuration writes
   input  logic                            csr_we,
   input  logic [sgr_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [sgr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sgr_pkg::*;

   localparam int RSP_DW = ((TIME_WIDTH + SPEED_W + 7) / 8) * 8;

   sgr_cfg_type cfg_ff, cfg_in;
   sgr_cmd_type cmd;
   sgr_sts_type sts;

   logic [1:0]            out_ev;
   logic [TIME_WIDTH-1:0] out_dur;
   logic [SPEED_W-1:0]    out_speed;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_REGION_MIN_X: cfg_in.region_min_x = $signed(csr_wdata);
            REG_REGION_MAX_X: cfg_in.region_max_x = $signed(csr_wdata);
            REG_REGION_MIN_Y: cfg_in.region_min_y = $signed(csr_wdata);
            REG_REGION_MAX_Y: cfg_in.region_max_y = $signed(csr_wdata);
            REG_BOUND_ENABLE: cfg_in.bound_enable = csr_wdata[3:0];
            REG_SWIPE_AXIS:   cfg_in.swipe_axis   = csr_wdata[0];
            REG_MIN_DISTANCE: cfg_in.min_distance = csr_wdata;
            REG_MIN_INTERVAL: cfg_in.min_interval = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.region_min_x <= RST_REGION_MIN;
         cfg_ff.region_max_x <= RST_REGION_MAX;
         cfg_ff.region_min_y <= RST_REGION_MIN;
         cfg_ff.region_max_y <= RST_REGION_MAX;
         cfg_ff.bound_enable <= RST_BOUND_EN;
         cfg_ff.swipe_axis   <= 1'b0;
         cfg_ff.min_distance <= '0;
         cfg_ff.min_interval <= RST_MIN_INTERVAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sgr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sgr_dpath #(
      .COORD_WIDTH (COORD_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .in_op     (req_tuser),
      .in_x      ($signed(req_tdata[COORD_WIDTH-1:0])),
      .in_y      ($signed(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
      .in_time   (req_tdata[2*COORD_WIDTH+TIME_WIDTH-1:2*COORD_WIDTH]),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .sts       (sts),
      .out_ev    (out_ev),
      .out_dur   (out_dur),
      .out_speed (out_speed)
   );

   assign rsp_tuser = out_ev;
   assign rsp_tdata = RSP_DW'({out_speed, out_dur});

endmodule

// ===== hw/rtl/sgr_ctrl.sv =====
module sgr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  sgr_pkg::sgr_sts_type sts,
   output sgr_pkg::sgr_cmd_type cmd
);
   import sgr_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Sequence one item: capture, evaluate, divide if needed, commit
   always_comb begin
      state_in      = state_ff;
      cmd.load_item = 1'b0;
      cmd.start_div = 1'b0;
      cmd.step_div  = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.need_speed) begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            cmd.step_div = 1'b1;
            if (sts.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until taken
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EVAL))
      else $error("accepted item did not move to evaluation");

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("commit would overwrite a pending result");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> (state_ff == ST_DIV || state_ff == ST_FIN))
      else $error("divider left without finishing");

endmodule

// ===== hw/rtl/sgr_dpath.sv =====
module sgr_dpath #(
   parameter int COORD_WIDTH = 16,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    in_op,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  logic [TIME_WIDTH-1:0]         in_time,
   input  sgr_pkg::sgr_cfg_type          cfg,
   input  sgr_pkg::sgr_cmd_type          cmd,
   output sgr_pkg::sgr_sts_type          sts,
   output logic [1:0]                    out_ev,
   output logic [TIME_WIDTH-1:0]         out_dur,
   output logic [sgr_pkg::SPEED_W-1:0]   out_speed
);
   import sgr_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int TW   = TIME_WIDTH;
   localparam int DW   = CW + 1;
   localparam int QW   = DW + FRAC_W;
   localparam int CNTW = $clog2(QW + 1);
   localparam int QXW  = (QW > SPEED_W + 1) ? QW : SPEED_W + 1;
   localparam int RW   = (CW > 16) ? CW : 16;
   localparam int MW   = (DW > 16) ? DW : 16;
   localparam logic [QXW-1:0] POS_LIM = QXW'({1'b0, {(SPEED_W-1){1'b1}}});
   localparam logic [QXW-1:0] NEG_LIM = QXW'({1'b1, {(SPEED_W-1){1'b0}}});

   // Captured item
   logic [1:0]           op_ff;
   logic signed [CW-1:0] x_ff, y_ff;
   logic [TW-1:0]        t_ff;

   // Gesture state
   logic                 armed_ff, armed_in;
   logic signed [CW-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic signed [CW-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CW-1:0] recent_x_ff, recent_x_in, recent_y_ff, recent_y_in;
   logic [TW-1:0]        upd_time_ff, upd_time_in, rec_time_ff, rec_time_in;
   logic [SPEED_W-1:0]   cur_speed_ff, cur_speed_in;

   // Divider
   logic [QW-1:0]   dvd_ff, dvd_in;
   logic [TW-1:0]   rem_ff, rem_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [TW:0]     rem_sh;
   logic [TW+1:0]   diff;
   logic            ge;

   // Result register
   logic [1:0]         ev_ff, ev_in;
   logic [TW-1:0]      dur_ff, dur_in;
   logic [SPEED_W-1:0] spd_ff, spd_in;

   logic [TW-1:0]      dt;
   logic [DW-1:0]      dx, dy, adx, ady, mag, ax, ay, travel;
   logic               neg, interval_ok, in_region, reached;
   logic [QXW-1:0]     q_ext, q_sat;
   logic [SPEED_W-1:0] new_speed;

   function automatic logic [DW-1:0] sdiff(input logic signed [CW-1:0] a,
                                           input logic signed [CW-1:0] b);
      return {a[CW-1], a} - {b[CW-1], b};
   endfunction

   function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] d);
      return d[DW-1] ? (~d + 1'b1) : d;
   endfunction

   // Elapsed time, dominant axis, start region and travel
   always_comb begin
      dt          = t_ff - upd_time_ff;
      interval_ok = (dt >= TW'(cfg.min_interval));
      dx          = sdiff(x_ff, prev_x_ff);
      dy          = sdiff(y_ff, prev_y_ff);
      adx         = mag_of(dx);
      ady         = mag_of(dy);
      if (adx > ady) begin
         mag = adx;
         neg = dx[DW-1];
      end else begin
         mag = ady;
         neg = dy[DW-1];
      end
      in_region = 1'b1;
      if (cfg.bound_enable[0] && (RW'($signed(cfg.region_min_x)) > RW'(x_ff))) begin
         in_region = 1'b0;
      end
      if (cfg.bound_enable[1] && (RW'($signed(cfg.region_max_x)) < RW'(x_ff))) begin
         in_region = 1'b0;
      end
      if (cfg.bound_enable[2] && (RW'($signed(cfg.region_min_y)) > RW'(y_ff))) begin
         in_region = 1'b0;
      end
      if (cfg.bound_enable[3] && (RW'($signed(cfg.region_max_y)) < RW'(y_ff))) begin
         in_region = 1'b0;
      end
      ax      = mag_of(sdiff(x_ff, start_x_ff));
      ay      = mag_of(sdiff(y_ff, start_y_ff));
      travel  = cfg.swipe_axis ? ax : ay;
      reached = (cfg.min_distance == 16'd0) || (MW'(travel) >= MW'(cfg.min_distance));
   end

   assign sts.need_speed = armed_ff &&
      (((op_ff == OP_MOVE) && interval_ok) ||
       ((op_ff == OP_RELEASE) && (!interval_ok || (cur_speed_ff == '0))));
   assign sts.div_last = (cnt_ff == CNTW'(1));

   // One restoring step: shift in a dividend bit, subtract when it fits
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[QW-1]};
      diff   = {1'b0, rem_sh} - {2'b00, dt};
      ge     = !diff[TW+1];
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.start_div) begin
         dvd_in = {mag, {FRAC_W{1'b0}}};
         rem_in = '0;
         cnt_in = CNTW'(QW);
      end else if (cmd.step_div) begin
         dvd_in = {dvd_ff[QW-2:0], ge};
         rem_in = ge ? diff[TW-1:0] : rem_sh[TW-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // Saturate and apply sign; zero elapsed time saturates through all-ones quotient
   always_comb begin
      q_ext = QXW'(dvd_ff);
      if (neg) begin
         q_sat = (q_ext > NEG_LIM) ? NEG_LIM : q_ext;
      end else begin
         q_sat = (q_ext > POS_LIM) ? POS_LIM : q_ext;
      end
      if ((dt == '0) && (mag == '0)) begin
         new_speed = '0;
      end else if (neg) begin
         new_speed = '0 - q_sat[SPEED_W-1:0];
      end else begin
         new_speed = q_sat[SPEED_W-1:0];
      end
   end

   // Next gesture state and result on commit
   always_comb begin
      armed_in     = armed_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      recent_x_in  = recent_x_ff;
      recent_y_in  = recent_y_ff;
      upd_time_in  = upd_time_ff;
      rec_time_in  = rec_time_ff;
      cur_speed_in = cur_speed_ff;
      ev_in        = ev_ff;
      dur_in       = dur_ff;
      spd_in       = spd_ff;
      if (cmd.commit) begin
         ev_in  = EV_NONE;
         dur_in = '0;
         spd_in = '0;
         case (op_ff)
            OP_PRESS: begin
               if (in_region) begin
                  armed_in    = 1'b1;
                  start_x_in  = x_ff;
                  prev_x_in   = x_ff;
                  recent_x_in = x_ff;
                  start_y_in  = y_ff;
                  prev_y_in   = y_ff;
                  recent_y_in = y_ff;
                  upd_time_in = t_ff;
                  rec_time_in = t_ff;
                  ev_in       = EV_STARTED;
               end
            end
            OP_MOVE: begin
               if (sts.need_speed) begin
                  cur_speed_in = new_speed;
                  upd_time_in  = rec_time_ff;
                  rec_time_in  = t_ff;
                  prev_x_in    = recent_x_ff;
                  prev_y_in    = recent_y_ff;
                  recent_x_in  = x_ff;
                  recent_y_in  = y_ff;
               end
            end
            OP_RELEASE: begin
               if (armed_ff) begin
                  dur_in = dt;
                  if (reached) begin
                     ev_in  = EV_TRIGGERED;
                     spd_in = sts.need_speed ? new_speed : cur_speed_ff;
                  end else begin
                     ev_in = EV_CANCELLED;
                  end
               end
               armed_in     = 1'b0;
               cur_speed_in = '0;
               upd_time_in  = '0;
               rec_time_in  = '0;
            end
            OP_CANCEL: begin
               if (armed_ff) begin
                  ev_in  = EV_CANCELLED;
                  dur_in = dt;
               end
               armed_in     = 1'b0;
               cur_speed_in = '0;
               upd_time_in  = '0;
               rec_time_in  = '0;
            end
            default: begin
               ev_in = EV_NONE;
            end
         endcase
      end
   end

   // Capture the item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff <= in_op;
         x_ff  <= in_x;
         y_ff  <= in_y;
         t_ff  <= in_time;
      end
   end

   // Divider and result registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      ev_ff  <= ev_in;
      dur_ff <= dur_in;
      spd_ff <= spd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         armed_ff     <= 1'b0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         recent_x_ff  <= '0;
         recent_y_ff  <= '0;
         upd_time_ff  <= '0;
         rec_time_ff  <= '0;
         cur_speed_ff <= '0;
      end else begin
         cnt_ff       <= cnt_in;
         armed_ff     <= armed_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         recent_x_ff  <= recent_x_in;
         recent_y_ff  <= recent_y_in;
         upd_time_ff  <= upd_time_in;
         rec_time_ff  <= rec_time_in;
         cur_speed_ff <= cur_speed_in;
      end
   end

   assign out_ev    = ev_ff;
   assign out_dur   = dur_ff;
   assign out_speed = spd_ff;

   a_step_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.step_div && !sts.div_last) |=> (cnt_ff != '0))
      else $error("divider count ran out early");

   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.start_div |=> (cnt_ff == CNTW'(QW)))
      else $error("divider not loaded with full step count");

   a_disarm: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (op_ff == OP_CANCEL || op_ff == OP_RELEASE)) |=>
      (!armed_ff && cur_speed_ff == '0))
      else $error("release or cancel left the gesture armed");

endmodule

// ===== sim/tb_swipe_gesture_recognizer.sv =====
module tb_swipe_gesture_recognizer;
   timeunit 1ns;
   timeprecision 1ps;

   import sgr_pkg::*;

   localparam int SCRIPT_ROWS  = 24;
   localparam int QUIET_LIMIT  = 3000;
   localparam int TAIL_CYCLES  = 64;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] px;
      logic [15:0] py;
      logic [31:0] ts;
   } pointer_item_type;

   typedef struct packed {
      logic [1:0]  ev;
      logic [31:0] dur;
      logic [31:0] spd;
   } gesture_result_type;

   typedef struct packed {
      pointer_item_type   item;
      logic               fixed_want;
      gesture_result_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser  = OP_PRESS;   // [1:0] op
   logic [63:0]           req_tdata  = '0;         // pos_x, pos_y, time_ms from bit 0 up
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [1:0]            rsp_tuser;               // [1:0] event_res
   logic [63:0]           rsp_tdata;               // duration_ms, speed from bit 0 up
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = REG_REGION_MIN_X;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Shadow copy of the configuration registers
   int          lim_min_x   = RST_REGION_MIN;
   int          lim_max_x   = RST_REGION_MAX;
   int          lim_min_y   = RST_REGION_MIN;
   int          lim_max_y   = RST_REGION_MAX;
   logic [3:0]  bound_mask  = RST_BOUND_EN;
   bit          axis_horiz  = 1'b0;
   int          travel_min  = 0;
   logic [15:0] sample_gap  = RST_MIN_INTERVAL;

   // Predicted gesture state
   bit          armed       = 1'b0;
   int          start_x     = 0;
   int          start_y     = 0;
   int          prev_x      = 0;
   int          prev_y      = 0;
   int          recent_x    = 0;
   int          recent_y    = 0;
   logic [31:0] update_ms   = '0;
   logic [31:0] recent_ms   = '0;
   logic [31:0] cur_rate    = '0;

   gesture_result_type pending_results[$];
   gesture_result_type oldest_result;
   int                 mismatch_count = 0;
   int                 results_seen   = 0;
   int                 quiet_cycles   = 0;
   int                 burst_left     = 0;
   logic [31:0]        now_ms         = '0;
   logic [15:0]        stall_tick     = '0;
   script_row_type     script [SCRIPT_ROWS];

   swipe_gesture_recognizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Q16.16 rate of delta pixels over dt ms, truncated toward zero and saturated
   function automatic logic [31:0] q16_rate(input longint delta, input logic [31:0] dt);
      longint unsigned mag;
      longint unsigned quot;
      mag = (delta < 0) ? -delta : delta;
      mag = mag << 16;
      if (dt == 32'd0) begin
         if (mag == 0) return 32'h0000_0000;
         return (delta < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      quot = mag / {32'h0, dt};
      if (delta < 0) begin
         if (quot > 64'h8000_0000) quot = 64'h8000_0000;
         quot = -quot;
      end else if (quot > 64'h7FFF_FFFF) begin
         quot = 64'h7FFF_FFFF;
      end
      return quot[31:0];
   endfunction

   function automatic int abs_int(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // Rate on the axis that moved most since prev, y on ties
   function automatic logic [31:0] dominant_rate(input int x, input int y,
                                                 input logic [31:0] dt);
      int dx;
      int dy;
      dx = x - prev_x;
      dy = y - prev_y;
      if (abs_int(dx) > abs_int(dy)) return q16_rate(dx, dt);
      return q16_rate(dy, dt);
   endfunction

   // Advance the gesture state by one item and return its result
   function automatic gesture_result_type predict_gesture(input pointer_item_type it);
      gesture_result_type res;
      int                 x;
      int                 y;
      logic [31:0]        dt;
      bit                 in_bounds;
      bit                 reached;
      int                 travel;
      x = int'($signed(it.px));
      y = int'($signed(it.py));
      dt = it.ts - update_ms;
      res = '{EV_NONE, 32'd0, 32'd0};
      case (it.op)
         OP_PRESS: begin
            in_bounds = 1'b1;
            if (bound_mask[0] && lim_min_x > x) in_bounds = 1'b0;
            if (bound_mask[1] && lim_max_x < x) in_bounds = 1'b0;
            if (bound_mask[2] && lim_min_y > y) in_bounds = 1'b0;
            if (bound_mask[3] && lim_max_y < y) in_bounds = 1'b0;
            if (in_bounds) begin
               armed = 1'b1;
               start_x = x; prev_x = x; recent_x = x;
               start_y = y; prev_y = y; recent_y = y;
               update_ms = it.ts;
               recent_ms = it.ts;
               res.ev = EV_STARTED;
            end
         end
         OP_MOVE: begin
            if (armed && dt >= sample_gap) begin
               cur_rate = dominant_rate(x, y, dt);
               update_ms = recent_ms;
               recent_ms = it.ts;
               prev_x = recent_x;
               prev_y = recent_y;
               recent_x = x;
               recent_y = y;
            end
         end
         OP_RELEASE: begin
            if (armed) begin
               if (dt < sample_gap || cur_rate == 32'd0) cur_rate = dominant_rate(x, y, dt);
               travel = axis_horiz ? abs_int(x - start_x) : abs_int(y - start_y);
               reached = (travel_min == 0) || (travel >= travel_min);
               res.dur = dt;
               if (reached) begin
                  res.ev = EV_TRIGGERED;
                  res.spd = cur_rate;
               end else begin
                  res.ev = EV_CANCELLED;
               end
            end
         end
         default: begin
            if (armed) begin
               res.ev = EV_CANCELLED;
               res.dur = dt;
            end
         end
      endcase
      // release and cancel always disarm
      if (it.op == OP_RELEASE || it.op == OP_CANCEL) begin
         armed = 1'b0;
         cur_rate = '0;
         update_ms = '0;
         recent_ms = '0;
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("[%0t] result %0d: %s got %h want %h", $time, results_seen, what, got, want);
      mismatch_count++;
   endtask

   // Offer one item in bursts, wait for it to be taken, record its expected result
   task automatic send_item(input pointer_item_type it, input bit fixed_want,
                            input gesture_result_type want);
      int                 gap;
      gesture_result_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {it.ts, it.py, it.px};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      predicted = predict_gesture(it);
      pending_results.push_back(fixed_want ? want : predicted);
   endtask

   task automatic send_random(input pointer_item_type it, inout int tries);
      send_item(it, 1'b0, '0);
      tries++;
   endtask

   // Stop offering items and wait until every result has come back
   task automatic settle_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_REGION_MIN_X: lim_min_x = int'($signed(val));
         REG_REGION_MAX_X: lim_max_x = int'($signed(val));
         REG_REGION_MIN_Y: lim_min_y = int'($signed(val));
         REG_REGION_MAX_Y: lim_max_y = int'($signed(val));
         REG_BOUND_ENABLE: bound_mask = val[3:0];
         REG_SWIPE_AXIS:   axis_horiz = val[0];
         REG_MIN_DISTANCE: travel_min = int'(val);
         default:          sample_gap = val;
      endcase
   endtask

   task automatic apply_config(input int mnx, input int mxx, input int mny, input int mxy,
                               input int be, input int ax, input int md, input int mi);
      settle_results();
      write_csr(REG_REGION_MIN_X, 16'(mnx));
      write_csr(REG_REGION_MAX_X, 16'(mxx));
      write_csr(REG_REGION_MIN_Y, 16'(mny));
      write_csr(REG_REGION_MAX_Y, 16'(mxy));
      write_csr(REG_BOUND_ENABLE, 16'(be));
      write_csr(REG_SWIPE_AXIS,   16'(ax));
      write_csr(REG_MIN_DISTANCE, 16'(md));
      write_csr(REG_MIN_INTERVAL, 16'(mi));
      csr_we <= 1'b0;
   endtask

   task automatic random_config();
      int lo_x;
      int lo_y;
      int md;
      int mi;
      lo_x = int'($urandom_range(0, 65535)) - 32768;
      lo_y = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 3))
         0:       md = 0;
         1, 2:    md = $urandom_range(1, 400);
         default: md = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 3))
         0:       mi = 0;
         1:       mi = $urandom_range(1, 50);
         2:       mi = $urandom_range(100, 1000);
         default: mi = int'(RST_MIN_INTERVAL);
      endcase
      apply_config(lo_x, lo_x + int'($urandom_range(0, 32767 - lo_x)),
                   lo_y, lo_y + int'($urandom_range(0, 32767 - lo_y)),
                   $urandom_range(0, 15), $urandom_range(0, 1), md, mi);
   endtask

   // Coordinate inside the enabled bounds, or anywhere if they leave no room
   function automatic logic [15:0] pick_coord(input int lo, input int hi,
                                              input bit use_lo, input bit use_hi);
      int l;
      int h;
      l = use_lo ? lo : -32768;
      h = use_hi ? hi : 32767;
      if (l > h) return 16'($urandom());
      return 16'(l + int'($urandom_range(0, h - l)));
   endfunction

   function automatic logic [15:0] wander(input logic [15:0] p);
      case ($urandom_range(0, 5))
         0, 1, 2: return 16'($signed(p) + int'($urandom_range(0, 128)) - 64);
         3:       return 16'($signed(p) + int'($urandom_range(0, 4000)) - 2000);
         4:       return 16'($urandom());
         default: return p;
      endcase
   endfunction

   // Time step around the sampling interval, sometimes early, sometimes huge
   function automatic logic [31:0] next_gap_ms();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, sample_gap);
         1, 2:    return sample_gap + $urandom_range(0, 300);
         3:       return $urandom_range(0, 4000);
         4:       return 32'd0;
         default: return $urandom();
      endcase
   endfunction

   // Mostly press/move/end gestures with random content, some noise items
   task automatic run_phase(input int target);
      int               tries;
      int               roll;
      logic [15:0]      cur_x;
      logic [15:0]      cur_y;
      pointer_item_type it;
      tries = 0;
      while (tries < target) begin
         if ($urandom_range(0, 99) < 12) begin
            it.op = 2'($urandom_range(0, 3));
            it.px = 16'($urandom());
            it.py = 16'($urandom());
            it.ts = $urandom();
            send_random(it, tries);
         end else begin
            if ($urandom_range(0, 7) == 0) now_ms = $urandom();
            else now_ms += $urandom_range(0, 5000);
            if ($urandom_range(0, 7) == 0) begin
               cur_x = 16'($urandom());
               cur_y = 16'($urandom());
            end else begin
               cur_x = pick_coord(lim_min_x, lim_max_x, bound_mask[0], bound_mask[1]);
               cur_y = pick_coord(lim_min_y, lim_max_y, bound_mask[2], bound_mask[3]);
            end
            it = '{OP_PRESS, cur_x, cur_y, now_ms};
            send_random(it, tries);
            repeat ($urandom_range(0, 6)) begin
               now_ms += next_gap_ms();
               cur_x = wander(cur_x);
               cur_y = wander(cur_y);
               it = '{OP_MOVE, cur_x, cur_y, now_ms};
               send_random(it, tries);
            end
            // end the gesture, or leave it armed for the next press
            roll = $urandom_range(0, 19);
            if (roll < 18) begin
               now_ms += next_gap_ms();
               cur_x = wander(cur_x);
               cur_y = wander(cur_y);
               it = '{(roll < 15) ? OP_RELEASE : OP_CANCEL, cur_x, cur_y, now_ms};
               send_random(it, tries);
            end
         end
      end
   endtask

   // Check each result against the oldest expectation; stall on a rotating pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               flag_mismatch("unexpected result, event", 32'(rsp_tuser), 32'(EV_NONE));
            end else begin
               oldest_result = pending_results.pop_front();
               if (rsp_tuser !== oldest_result.ev)
                  flag_mismatch("event", 32'(rsp_tuser), 32'(oldest_result.ev));
               if (rsp_tdata[31:0] !== oldest_result.dur)
                  flag_mismatch("duration_ms", rsp_tdata[31:0], oldest_result.dur);
               if (rsp_tdata[63:32] !== oldest_result.spd)
                  flag_mismatch("speed", rsp_tdata[63:32], oldest_result.spd);
            end
         end
         stall_tick <= stall_tick + 16'd1;
         case (stall_tick[10:9])
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
            2'd2:    rsp_tready <= (stall_tick[2:0] == 3'd0);
            default: rsp_tready <= ~stall_tick[3];
         endcase
      end
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      pointer_item_type it;
      script = '{
         // nothing armed: release, cancel and move report none
         '{'{OP_RELEASE, 16'd0, 16'd0, 32'd0},    1'b1, '{EV_NONE, 32'd0, 32'd0}},
         '{'{OP_CANCEL,  16'd7, 16'd7, 32'd10},   1'b1, '{EV_NONE, 32'd0, 32'd0}},
         '{'{OP_MOVE,    16'd1, 16'd1, 32'd600},  1'b1, '{EV_NONE, 32'd0, 32'd0}},
         // press outside the region on min x and on min y
         '{'{OP_PRESS, 16'hFFFF, 16'd5, 32'd1000}, 1'b1, '{EV_NONE, 32'd0, 32'd0}},
         '{'{OP_PRESS, 16'd5, 16'h8000, 32'd1000}, 1'b1, '{EV_NONE, 32'd0, 32'd0}},
         // arm, early move, sampled moves, release
         '{'{OP_PRESS, 16'd0, 16'd0, 32'd1000},   1'b1, '{EV_STARTED, 32'd0, 32'd0}},
         '{'{OP_MOVE,  16'd0, 16'd100, 32'd1100}, 1'b1, '{EV_NONE, 32'd0, 32'd0}},
         '{'{OP_MOVE,  16'd0, 16'd100, 32'd1500}, 1'b1, '{EV_NONE, 32'd0, 32'd0}},
         '{'{OP_MOVE,  16'hFED4, 16'd150, 32'd2100}, 1'b0, '{EV_NONE, 32'd0, 32'd0}},
         '{'{OP_RELEASE, 16'hFECA, 16'd400, 32'd2200}, 1'b0, '{EV_NONE, 32'd0, 32'd0}},
         // re-press while armed, then cancel
         '{'{OP_PRESS,  16'd100, 16'd200, 32'd3000}, 1'b1, '{EV_STARTED, 32'd0, 32'd0}},
         '{'{OP_PRESS,  16'd300, 16'd400, 32'd3050}, 1'b1, '{EV_STARTED, 32'd0, 32'd0}},
         '{'{OP_CANCEL, 16'd0, 16'd0, 32'd3350},  1'b1, '{EV_CANCELLED, 32'd300, 32'd0}},
         // zero elapsed time saturates in the sign of the travel
         '{'{OP_PRESS,   16'd0, 16'd0, 32'd4000},     1'b1, '{EV_STARTED, 32'd0, 32'd0}},
         '{'{OP_RELEASE, 16'h7FFF, 16'd0, 32'd4000},  1'b1,
           '{EV_TRIGGERED, 32'd0, 32'h7FFF_FFFF}},
         '{'{OP_PRESS,   16'h7FFF, 16'h7FFF, 32'd5000}, 1'b1, '{EV_STARTED, 32'd0, 32'd0}},
         '{'{OP_RELEASE, 16'h8000, 16'h7FFF, 32'd5000}, 1'b1,
           '{EV_TRIGGERED, 32'd0, 32'h8000_0000}},
         // zero elapsed time with no travel gives zero speed
         '{'{OP_PRESS,   16'd5, 16'd5, 32'd6000}, 1'b1, '{EV_STARTED, 32'd0, 32'd0}},
         '{'{OP_RELEASE, 16'd5, 16'd5, 32'd6000}, 1'b1, '{EV_TRIGGERED, 32'd0, 32'd0}},
         // timestamp wrap, release recomputes a zero speed
         '{'{OP_PRESS,   16'd0, 16'd0, 32'hFFFF_FF00}, 1'b1, '{EV_STARTED, 32'd0, 32'd0}},
         '{'{OP_MOVE,    16'd0, 16'd0, 32'h0000_0100}, 1'b1, '{EV_NONE, 32'd0, 32'd0}},
         '{'{OP_RELEASE, 16'd0, 16'd1, 32'h0000_0180}, 1'b0, '{EV_NONE, 32'd0, 32'd0}},
         // stale sample recomputed on a one millisecond release
         '{'{OP_PRESS,   16'd10, 16'd10, 32'd7000},    1'b1, '{EV_STARTED, 32'd0, 32'd0}},
         '{'{OP_RELEASE, 16'd20, 16'h8AD0, 32'd7001},  1'b0, '{EV_NONE, 32'd0, 32'd0}}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed items under the reset configuration
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         it = script[i].item;
         send_item(it, script[i].fixed_want, script[i].want);
      end
      run_phase(120);

      // widest region, horizontal, no interval
      apply_config(-32768, 32767, -32768, 32767, 15, 1, 100, 0);
      run_phase(128);
      // inverted bounds all disabled, largest distance and interval
      apply_config(32767, -32768, 32767, -32768, 0, 0, 65535, 65535);
      run_phase(128);
      // narrow x band, only x bounds checked
      apply_config(-100, 100, -32768, 32767, 3, 1, 0, 1);
      run_phase(128);
      for (int p = 0; p < 5; p++) begin
         random_config();
         run_phase(128);
      end

      settle_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
